### rtl/xmcrc_pkg.sv
// xmcrc_pkg: types, character codes and the crc-16 byte update for the xmodem-1k receiver
// no dependencies; imported by xmodem_1k_crc_receiver_top
`default_nettype none
package xmcrc_pkg;

   localparam int BLOCK_BYTES = 1024;
   localparam int IDX_W       = $clog2(BLOCK_BYTES + 4);
   localparam int LEAD_W      = 4;
   localparam int BEAT_W      = 5;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_ESC = 8'd27;
   localparam logic [7:0] CH_CR  = 8'd13;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;
   localparam logic [15:0] CRC_MASK = 16'hFFFF;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_BLOCK  = 3'd2;
   localparam logic [2:0] PH_DRAIN  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_FAIL  = 2'd2;
   localparam logic [1:0] ST_BLOCK = 2'd3;

   localparam logic [LEAD_W-1:0] LEAD_ONE     = LEAD_W'(1);
   localparam logic [LEAD_W-1:0] LEAD_NAK_RUN = LEAD_W'(9);
   localparam logic [LEAD_W-1:0] LEAD_DRAIN   = LEAD_W'(10);
   localparam logic [BEAT_W-1:0] CAN_RUN      = BEAT_W'(8);

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [1:0] status;
      logic [7:0] block_seq;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        lead_byte;
      logic [LEAD_W-1:0] lead_cnt;
      logic [BEAT_W-1:0] total;
      logic [1:0]        status;
      logic [7:0]        block_seq;
   } burst_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = (c ^ {b, 8'h00}) & CRC_MASK;
      for (int i = 0; i < 8; i++) begin
         if ((x & CRC_TOP) != 16'h0000) begin
            x = {x[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            x = {x[14:0], 1'b0};
         end
      end
      return x;
   endfunction

endpackage
`default_nettype wire

### rtl/xmodem_1k_crc_receiver_top.sv
// xmodem-1k receiver with crc-16: protocol state, block checks and reply byte sequencer
// depends on xmcrc_pkg
//
// One input beat (a received byte or a tick) is taken per clock while the
// two-entry reply queue has room and no retry limit write is under way; the protocol state,
// block number checks and the bytewise crc-16 update are all settled in the cycle the beat
// is accepted. Each input that causes replies queues one burst of up to 18 result beats ('C',
// ACK, NAK, CAN), which leave one per cycle on the rsp side while rsp_stall is low, so
// sustained input rate is one per cycle except while two bursts wait for the result side to
// drain. Once the transfer has completed or failed, inputs are taken and ignored until reset.
`default_nettype none
module xmodem_1k_crc_receiver_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  xmcrc_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output xmcrc_pkg::rsp_type  rsp_data,
   input  wire                 csr_wr_en,
   input  wire  [7:0]          csr_wr_data
);
   import xmcrc_pkg::*;

   logic [7:0]       retry_limit_ff;
   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       retries_ff, retries_in;
   logic [7:0]       exp_ff, exp_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic             hok_ff, hok_in;
   logic [7:0]       rhi_ff, rhi_in;

   burst_type        q_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [BEAT_W-1:0] beat_ff;

   logic             accept, push, pop, fire;
   logic             tick, hdr, attempt, fail;
   logic [7:0]       b, dec;
   logic [7:0]       lead_byte;
   logic [LEAD_W-1:0] lead_cnt;
   logic [1:0]       status;
   logic [BEAT_W-1:0] total;
   burst_type        head;
   logic             last_beat;

   assign tick   = req_data.operation;
   assign b      = req_data.rx_byte;
   assign dec    = retries_ff - 8'd1;
   assign accept = req_valid && !req_stall;

   always_comb begin
      phase_in   = phase_ff;
      retries_in = retries_ff;
      exp_in     = exp_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      hok_in     = hok_ff;
      rhi_in     = rhi_ff;
      lead_byte  = CH_NAK;
      lead_cnt   = '0;
      fail       = 1'b0;
      status     = ST_RUN;
      hdr        = 1'b0;
      attempt    = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (tick) begin
               lead_byte  = CH_C;
               lead_cnt   = LEAD_ONE;
               retries_in = dec;
               fail       = (dec == 8'd0);
            end else if (b == CH_ESC) begin
               fail = 1'b1;
            end else if (b == CH_CR) begin
               retries_in = dec;
               fail       = (dec == 8'd0);
            end else begin
               retries_in = retry_limit_ff;
               exp_in     = 8'd1;
               hdr        = 1'b1;
            end
         end
         PH_HEADER: begin
            if (tick) attempt = 1'b1;
            else      hdr     = 1'b1;
         end
         PH_BLOCK: begin
            if (tick) begin
               attempt = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(0)) begin
                  hok_in = (b == exp_ff);
               end else if (idx_ff == IDX_W'(1)) begin
                  hok_in = hok_ff && (~b == exp_ff);
               end else if (idx_ff < IDX_W'(BLOCK_BYTES + 2)) begin
                  crc_in = crc_byte(crc_ff, b);
               end else if (idx_ff == IDX_W'(BLOCK_BYTES + 2)) begin
                  rhi_in = b;
               end else begin
                  idx_in = idx_ff;
                  if (hok_ff && ({rhi_ff, b} == crc_ff)) begin
                     lead_byte  = CH_ACK;
                     lead_cnt   = LEAD_ONE;
                     exp_in     = exp_ff + 8'd1;
                     retries_in = retry_limit_ff;
                     status     = ST_BLOCK;
                     phase_in   = PH_HEADER;
                  end else begin
                     lead_cnt = LEAD_NAK_RUN;
                     fail     = 1'b1;
                  end
               end
            end
         end
         PH_DRAIN: begin
            if (tick) begin
               lead_cnt   = LEAD_ONE;
               retries_in = dec;
               if (dec == 8'd0) begin
                  lead_cnt = LEAD_DRAIN;
                  fail     = 1'b1;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         end
         default: begin
         end
      endcase

      if (attempt) begin
         retries_in = dec;
         if (dec == 8'd0) fail     = 1'b1;
         else             phase_in = PH_HEADER;
      end

      if (hdr) begin
         case (b)
            CH_SOH: begin
               lead_cnt = LEAD_NAK_RUN;
               fail     = 1'b1;
            end
            CH_STX: begin
               phase_in = PH_BLOCK;
               idx_in   = '0;
               crc_in   = '0;
               hok_in   = 1'b0;
               rhi_in   = '0;
            end
            CH_CAN: begin
               lead_byte = CH_ACK;
               lead_cnt  = LEAD_ONE;
               fail      = 1'b1;
            end
            CH_EOT: begin
               lead_byte = CH_ACK;
               lead_cnt  = LEAD_ONE;
               status    = ST_DONE;
               phase_in  = PH_DONE;
            end
            default: begin
               phase_in = PH_DRAIN;
            end
         endcase
      end

      if (fail) begin
         status   = ST_FAIL;
         phase_in = PH_DONE;
      end

      total = BEAT_W'(lead_cnt) + (fail ? CAN_RUN : BEAT_W'(0));
   end

   // reply queue and beat sequencer
   assign head      = q_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != 2'd0);
   assign last_beat = (beat_ff == head.total - BEAT_W'(1));
   assign fire      = rsp_valid && !rsp_stall;
   assign pop       = fire && last_beat;
   assign push      = accept && (total != BEAT_W'(0));
   assign req_stall = (count_ff == 2'd2) || csr_wr_en;

   always_comb begin
      rsp_data.tx_valid  = 1'b1;
      rsp_data.tx_byte   = (beat_ff < BEAT_W'(head.lead_cnt)) ? head.lead_byte : CH_CAN;
      rsp_data.status    = head.status;
      rsp_data.block_seq = head.block_seq;
      rsp_data.last      = last_beat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 8'd10;
         phase_ff       <= PH_START;
         retries_ff     <= 8'd10;
         exp_ff         <= 8'd1;
         idx_ff         <= '0;
         crc_ff         <= '0;
         hok_ff         <= 1'b0;
         rhi_ff         <= '0;
      end else if (csr_wr_en) begin
         retry_limit_ff <= csr_wr_data;
         if (phase_ff == PH_START) retries_ff <= csr_wr_data;
      end else if (accept) begin
         phase_ff   <= phase_in;
         retries_ff <= retries_in;
         exp_ff     <= exp_in;
         idx_ff     <= idx_in;
         crc_ff     <= crc_in;
         hok_ff     <= hok_in;
         rhi_ff     <= rhi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{lead_byte: lead_byte, lead_cnt: lead_cnt, total: total,
                              status: status, block_seq: exp_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         beat_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
         if (fire) beat_ff <= last_beat ? BEAT_W'(0) : beat_ff + BEAT_W'(1);
      end
   end

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("reply queue overflow");

   a_beat_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> beat_ff < head.total) else $error("beat counter past burst end");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DONE) |-> !push) else $error("reply after transfer end");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !$past(reset)) |=> phase_ff == PH_DONE)
      else $error("left done phase without reset");

endmodule
`default_nettype wire

### tb/xmodem_1k_crc_receiver_checker.sv
// xmodem-1k receiver checker: watches the request, reply and csr ports, predicts reply beats
// from its own protocol state and compares them in order; depends on xmcrc_pkg
module xmodem_1k_crc_receiver_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  xmcrc_pkg::req_type  req_data,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  xmcrc_pkg::rsp_type  rsp_data,
   input  wire                 csr_wr_en,
   input  wire  [7:0]          csr_wr_data,
   output int                  mismatches,
   output int                  replies_due
);
   import xmcrc_pkg::*;

   logic [7:0]  limit_r;
   logic [7:0]  tries;
   logic [7:0]  next_blk;
   logic [2:0]  ph;
   logic [10:0] idx;
   logic [15:0] crc_acc;
   logic        hdr_good;
   logic [7:0]  crc_hi;

   logic [7:0]  burst_bytes [0:17];
   int          burst_len;
   logic [1:0]  outcome;

   rsp_type     reply_q [$];
   rsp_type     want;
   int          fail_tally = 0;

   function automatic void add_byte(input logic [7:0] b);
      if (burst_len < 18) begin
         burst_bytes[burst_len] = b;
         burst_len++;
      end
   endfunction

   function automatic void add_naks();
      repeat (9) add_byte(CH_NAK);
   endfunction

   function automatic void give_up();
      repeat (8) add_byte(CH_CAN);
      outcome = ST_FAIL;
      ph = PH_DONE;
   endfunction

   function automatic void spend_try();
      tries = tries - 8'd1;
      if (tries == 8'd0) begin
         give_up();
      end else begin
         ph = PH_HEADER;
      end
   endfunction

   function automatic void take_header(input logic [7:0] b);
      if (b == CH_SOH) begin
         add_naks();
         give_up();
      end else if (b == CH_STX) begin
         ph = PH_BLOCK;
         idx = '0;
         crc_acc = 16'h0000;
         hdr_good = 1'b0;
         crc_hi = 8'h00;
      end else if (b == CH_CAN) begin
         add_byte(CH_ACK);
         give_up();
      end else if (b == CH_EOT) begin
         add_byte(CH_ACK);
         outcome = ST_DONE;
         ph = PH_DONE;
      end else begin
         ph = PH_DRAIN;
      end
   endfunction

   task automatic predict_replies(input req_type r);
      logic        tick;
      logic [7:0]  b;
      logic [15:0] x;
      rsp_type     e;
      int          i;
      tick = r.operation;
      b = r.rx_byte;
      burst_len = 0;
      outcome = ST_RUN;
      case (ph)
         PH_START: begin
            if (tick) begin
               add_byte(CH_C);
               tries = tries - 8'd1;
               if (tries == 8'd0) give_up();
            end else if (b == CH_ESC) begin
               give_up();
            end else if (b == CH_CR) begin
               tries = tries - 8'd1;
               if (tries == 8'd0) give_up();
            end else begin
               tries = limit_r;
               next_blk = 8'd1;
               take_header(b);
            end
         end
         PH_HEADER: begin
            if (tick) spend_try();
            else take_header(b);
         end
         PH_BLOCK: begin
            if (tick) begin
               spend_try();
            end else if (idx == 11'd0) begin
               hdr_good = (b == next_blk);
               idx++;
            end else if (idx == 11'd1) begin
               hdr_good = hdr_good && ((~b) == next_blk);
               idx++;
            end else if (idx < 11'(BLOCK_BYTES + 2)) begin
               x = crc_acc ^ {b, 8'h00};
               for (i = 0; i < 8; i++) begin
                  x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
               end
               crc_acc = x;
               idx++;
            end else if (idx == 11'(BLOCK_BYTES + 2)) begin
               crc_hi = b;
               idx++;
            end else if (hdr_good && {crc_hi, b} == crc_acc) begin
               add_byte(CH_ACK);
               next_blk = next_blk + 8'd1;
               tries = limit_r;
               outcome = ST_BLOCK;
               ph = PH_HEADER;
            end else begin
               add_naks();
               give_up();
            end
         end
         PH_DRAIN: begin
            if (tick) begin
               add_byte(CH_NAK);
               tries = tries - 8'd1;
               if (tries == 8'd0) begin
                  add_naks();
                  give_up();
               end else begin
                  ph = PH_HEADER;
               end
            end
         end
         default: ;
      endcase
      for (i = 0; i < burst_len; i++) begin
         e.tx_valid = 1'b1;
         e.tx_byte = burst_bytes[i];
         e.status = outcome;
         e.block_seq = next_blk;
         e.last = (i == burst_len - 1);
         reply_q.push_back(e);
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] got_v);
      if (exp_v !== got_v) begin
         fail_tally++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limit_r = 8'd10;
         tries = 8'd10;
         next_blk = 8'd1;
         ph = PH_START;
         idx = '0;
         crc_acc = 16'h0000;
         hdr_good = 1'b0;
         crc_hi = 8'h00;
         reply_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               fail_tally++;
               $display("%0t: reply beat with none expected, actual byte %0h status %0d",
                        $time, rsp_data.tx_byte, rsp_data.status);
            end else begin
               want = reply_q.pop_front();
               check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_data.tx_valid));
               check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
               check_field("status", 8'(want.status), 8'(rsp_data.status));
               check_field("block_seq", want.block_seq, rsp_data.block_seq);
               check_field("last", 8'(want.last), 8'(rsp_data.last));
            end
         end
         if (csr_wr_en) begin
            limit_r = csr_wr_data;
            if (ph == PH_START) tries = csr_wr_data;
         end
         if (req_valid && !req_stall) predict_replies(req_data);
      end
      mismatches <= fail_tally;
      replies_due <= reply_q.size();
   end

endmodule

### tb/xmodem_1k_crc_receiver_top_tb.sv
// testbench top for xmodem_1k_crc_receiver_top: clock, reset, retry limit writes and byte or
// tick beats with random idling; depends on xmcrc_pkg and xmodem_1k_crc_receiver_checker
module xmodem_1k_crc_receiver_top_tb;
   import xmcrc_pkg::*;

   localparam logic OP_BYTE        = 1'b0;
   localparam logic OP_TICK        = 1'b1;
   localparam int   SETTLE_CYCLES  = 8;
   localparam int   WATCHDOG_LIMIT = 2000;

   typedef enum int {
      END_EOT, END_CAN, END_SOH, END_BAD_SEQ, END_BAD_CPL, END_BAD_CRC,
      END_HDR_OUT, END_BLK_OUT, END_DRAIN_OUT, END_ESC, END_START_OUT
   } ending_e;

   typedef enum int {FLT_NONE, FLT_SEQ, FLT_CPL, FLT_CRC, FLT_CUT} blk_fault_e;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   int         mismatches;
   int         replies_due;
   logic       calm_tail = 1'b0;
   int         hold_cnt = 0;
   int         idle_cycles = 0;

   bit         sender_gaps = 1'b1;
   logic [7:0] blk_no = 8'd1;
   int         limit_val = 10;
   int         tries_left = 10;
   ending_e    finale;

   xmodem_1k_crc_receiver_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   xmodem_1k_crc_receiver_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .replies_due (replies_due)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // reply side: stall bursts between free stretches, until calm_tail is set
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (calm_tail || rsp_stall) begin
         rsp_stall <= 1'b0;
         hold_cnt <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 30);
      end else begin
         rsp_stall <= 1'b1;
         hold_cnt <= $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] b);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {op, b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (replies_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      limit_val = int'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_drain();
      logic [7:0] b;
      int         n;
      do begin
         b = 8'($urandom);
      end while (b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_CAN ||
                 b == CH_ESC || b == CH_CR);
      send_beat(OP_BYTE, b);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      repeat (n) send_beat(OP_BYTE, 8'($urandom));
      send_beat(OP_TICK, 8'($urandom));
      tries_left--;
   endtask

   task automatic send_block(input blk_fault_e fault, input int cut);
      logic [7:0]  d;
      logic [7:0]  seq_b;
      logic [7:0]  cpl_b;
      logic [15:0] crc;
      int          fill;
      int          i;
      int          j;
      seq_b = blk_no;
      cpl_b = ~blk_no;
      crc = 16'h0000;
      fill = $urandom_range(0, 7);
      if (fault == FLT_SEQ) seq_b = blk_no ^ 8'($urandom_range(1, 255));
      if (fault == FLT_CPL) cpl_b = cpl_b ^ 8'($urandom_range(1, 255));
      send_beat(OP_BYTE, CH_STX);
      for (i = 0; i < BLOCK_BYTES + 4; i++) begin
         if (fault == FLT_CUT && i == cut) break;
         if (i == 0) begin
            d = seq_b;
         end else if (i == 1) begin
            d = cpl_b;
         end else if (i < BLOCK_BYTES + 2) begin
            d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            crc = crc ^ {d, 8'h00};
            for (j = 0; j < 8; j++) begin
               crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
            end
         end else begin
            if (i == BLOCK_BYTES + 2 && fault == FLT_CRC) begin
               crc = crc ^ 16'($urandom_range(1, 65535));
            end
            d = (i == BLOCK_BYTES + 2) ? crc[15:8] : crc[7:0];
         end
         send_beat(OP_BYTE, d);
      end
      if (fault == FLT_CUT) begin
         send_beat(OP_TICK, 8'($urandom));
         tries_left--;
      end else if (fault == FLT_NONE) begin
         blk_no++;
         tries_left = (limit_val == 0) ? 256 : limit_val;
      end
   endtask

   initial begin
      int         pick;
      int         episodes;
      logic [7:0] lim;
      episodes = 0;
      pick = $urandom_range(0, 19);
      if (pick == 18) finale = END_ESC;
      else if (pick == 19) finale = END_START_OUT;
      else finale = ending_e'(pick % 9);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_limit(8'd255);
      send_beat(OP_TICK, 8'($urandom));
      send_beat(OP_BYTE, CH_CR);
      send_beat(OP_TICK, 8'($urandom));
      settle();
      write_limit(8'd0);
      send_beat(OP_TICK, 8'($urandom));

      if (finale == END_ESC) begin
         send_beat(OP_BYTE, CH_ESC);
      end else if (finale == END_START_OUT) begin
         settle();
         write_limit(8'd1);
         send_beat(OP_TICK, 8'($urandom));
      end else begin
         // unknown first header, drained bytes, then timeouts
         tries_left = 256;
         send_beat(OP_BYTE, 8'hFF);
         send_beat(OP_BYTE, 8'h00);
         send_beat(OP_BYTE, CH_STX);
         send_beat(OP_BYTE, CH_SOH);
         send_beat(OP_BYTE, CH_EOT);
         send_beat(OP_BYTE, CH_CAN);
         send_beat(OP_BYTE, CH_ESC);
         send_beat(OP_BYTE, CH_CR);
         send_beat(OP_TICK, 8'($urandom));
         tries_left--;
         send_beat(OP_TICK, 8'($urandom));
         tries_left--;

         while (episodes < 10) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
               settle();
               pick = $urandom_range(0, 4);
               lim = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(2, 254));
               write_limit(lim);
            end else if (pick == 8 && tries_left > 1) begin
               send_beat(OP_TICK, 8'($urandom));
               tries_left--;
            end else if (pick >= 6 && pick <= 7 && tries_left > 1) begin
               send_drain();
            end else if (tries_left > 1) begin
               send_block(FLT_CUT, $urandom_range(0, 40));
            end else begin
               send_block(FLT_NONE, 0);
            end
            if ($urandom_range(0, 7) == 0) settle();
            episodes++;
         end

         // last stretch: no idling, one attempt left after the final good block where one is sent
         settle();
         calm_tail <= 1'b1;
         sender_gaps = 1'b0;
         write_limit(8'd1);
         if (finale != END_BAD_SEQ && finale != END_BAD_CPL && finale != END_BAD_CRC) begin
            send_block(FLT_NONE, 0);
         end
         case (finale)
            END_EOT:     send_beat(OP_BYTE, CH_EOT);
            END_CAN:     send_beat(OP_BYTE, CH_CAN);
            END_SOH:     send_beat(OP_BYTE, CH_SOH);
            END_BAD_SEQ: send_block(FLT_SEQ, 0);
            END_BAD_CPL: send_block(FLT_CPL, 0);
            END_BAD_CRC: send_block(FLT_CRC, 0);
            END_HDR_OUT: send_beat(OP_TICK, 8'($urandom));
            END_BLK_OUT: send_block(FLT_CUT, $urandom_range(0, 40));
            default:     send_drain();
         endcase
      end

      // transfer is over, these beats must be swallowed
      calm_tail <= 1'b1;
      sender_gaps = 1'b0;
      repeat (12) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
      settle();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
